/* hdl/serial_line_command_parser_defines.svh */
// assertion macros for the serial line command parser
`ifndef SERIAL_LINE_COMMAND_PARSER_DEFINES_SVH
`define SERIAL_LINE_COMMAND_PARSER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SLCP_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SLCP_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/slcp_pkg.sv */
// shared types, character codes and keyword tables for the command parser
package slcp_pkg;

    localparam int LINE_LIMIT_DEF = 100;
    localparam int RATE_W         = 12;
    localparam logic [RATE_W-1:0] RATE_MIN_RST = 12'd200;
    localparam logic [RATE_W-1:0] RATE_MAX_RST = 12'd1300;
    localparam logic [RATE_W-1:0] RATE_SAT     = 12'd4095;

    // register indexes
    localparam logic CFG_RATE_MIN = 1'b0;
    localparam logic CFG_RATE_MAX = 1'b1;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QM    = 8'h3F;

    // keyword candidate bits
    localparam int CAND_RATE  = 0;
    localparam int CAND_STATE = 1;

    // value flag bits
    localparam int VF_STARTED = 0;
    localparam int VF_NEG     = 1;
    localparam int VF_BIG     = 2;
    localparam int VF_STOPPED = 3;

    typedef enum logic [1:0] {
        CMD_QUERY    = 2'd0,
        CMD_RATE     = 2'd1,
        CMD_PUMP_ON  = 2'd2,
        CMD_PUMP_OFF = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PH_BEFORE_KEY = 3'd0,
        PH_IN_KEY     = 3'd1,
        PH_BEFORE_VAL = 3'd2,
        PH_IN_VAL     = 3'd3,
        PH_VAL_DONE   = 3'd4,
        PH_IGNORE     = 3'd5
    } phase_t;

    // one parse result, handed from the parser core to the output register
    typedef struct packed {
        logic              hit;
        cmd_t              command;
        logic [RATE_W-1:0] rate;
    } res_t;

    // FLOWRATE, position 0..7
    function automatic logic [7:0] kw_rate_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h46; // F
            3'd1:    ch = 8'h4C; // L
            3'd2:    ch = 8'h4F; // O
            3'd3:    ch = 8'h57; // W
            3'd4:    ch = 8'h52; // R
            3'd5:    ch = 8'h41; // A
            3'd6:    ch = 8'h54; // T
            default: ch = 8'h45; // E
        endcase
        return ch;
    endfunction

    // FLOWSTATE, position 0..8
    function automatic logic [7:0] kw_state_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h46; // F
            4'd1:    ch = 8'h4C; // L
            4'd2:    ch = 8'h4F; // O
            4'd3:    ch = 8'h57; // W
            4'd4:    ch = 8'h53; // S
            4'd5:    ch = 8'h54; // T
            4'd6:    ch = 8'h41; // A
            4'd7:    ch = 8'h54; // T
            4'd8:    ch = 8'h45; // E
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // ON, position 0..1
    function automatic logic [7:0] kw_on_char(input logic pos);
        return pos ? 8'h4E : 8'h4F;
    endfunction

endpackage

/* hdl/slcp_core.sv */
// parse state registers and the per-word update and line-end decision
module slcp_core #(
    parameter int LINE_LIMIT = slcp_pkg::LINE_LIMIT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [7:0]                 byte_in,
    input  logic [slcp_pkg::RATE_W-1:0] lo_limit,
    input  logic [slcp_pkg::RATE_W-1:0] hi_limit,
    output slcp_pkg::res_t             res
);
    import slcp_pkg::*;

    localparam int CNT_W = (LINE_LIMIT > 2) ? $clog2(LINE_LIMIT) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_LIMIT - 1);

    logic [CNT_W-1:0]  count_reg, count_next;
    phase_t            phase_reg, phase_next;
    logic [3:0]        key_pos_reg, key_pos_next;
    logic [1:0]        cand_reg, cand_next;
    logic [1:0]        on_pos_reg, on_pos_next;
    logic [RATE_W-1:0] acc_reg, acc_next;
    logic [3:0]        flags_reg, flags_next;
    logic              question_reg, question_next;
    logic              ended_reg, ended_next;

    // key character match
    logic [3:0] key_pos_k;
    logic [1:0] cand_k;
    logic       rate_ok, state_ok;

    always_comb
    begin
        rate_ok  = (key_pos_reg < 4'd8) && (byte_in == kw_rate_char(key_pos_reg[2:0]));
        state_ok = (key_pos_reg < 4'd9) && (byte_in == kw_state_char(key_pos_reg));
        if (key_pos_reg == 4'hF)
        begin
            key_pos_k = key_pos_reg;
            cand_k    = 2'b00;
        end
        else
        begin
            key_pos_k = key_pos_reg + 4'd1;
            cand_k    = cand_reg & {state_ok, rate_ok};
        end
    end

    // key resolution at the end of the key token
    logic [1:0] cand_res;
    assign cand_res = cand_reg & {key_pos_reg == 4'd9, key_pos_reg == 4'd8};

    // value character: ON match and decimal accumulation
    logic [1:0]        on_pos_v;
    logic [RATE_W-1:0] acc_v;
    logic [3:0]        flags_v;
    logic [15:0]       acc_wide;

    always_comb
    begin
        if ((on_pos_reg < 2'd2) && (byte_in == kw_on_char(on_pos_reg[0])))
            on_pos_v = on_pos_reg + 2'd1;
        else
            on_pos_v = 2'd3;

        // times ten as two shifts, plus the digit
        acc_wide = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {12'd0, byte_in[3:0]};
        acc_v    = acc_reg;
        flags_v  = flags_reg;
        if (!flags_reg[VF_STOPPED])
        begin
            if (byte_in inside {[CH_ZERO:CH_NINE]})
            begin
                flags_v[VF_STARTED] = 1'b1;
                if (acc_wide > 16'(RATE_SAT))
                begin
                    acc_v          = RATE_SAT;
                    flags_v[VF_BIG] = 1'b1;
                end
                else
                begin
                    acc_v = acc_wide[RATE_W-1:0];
                end
            end
            else if (!flags_reg[VF_STARTED] && (byte_in inside {CH_SP, CH_TAB, CH_VT, CH_FF}))
            begin
                flags_v = flags_reg;
            end
            else if (!flags_reg[VF_STARTED] && (byte_in inside {CH_PLUS, CH_MINUS}))
            begin
                flags_v[VF_STARTED] = 1'b1;
                if (byte_in == CH_MINUS)
                    flags_v[VF_NEG] = 1'b1;
            end
            else
            begin
                flags_v[VF_STOPPED] = 1'b1;
            end
        end
    end

    // line-end decision
    logic [1:0] cand_f;
    logic       live, rate_ok_f, has_value;
    res_t       res_eol;

    always_comb
    begin
        cand_f    = (phase_reg == PH_IN_KEY) ? cand_res : cand_reg;
        live      = (phase_reg != PH_BEFORE_KEY) && (phase_reg != PH_IGNORE) && (cand_f != 2'b00);
        has_value = (phase_reg == PH_IN_VAL) || (phase_reg == PH_VAL_DONE);
        rate_ok_f = !flags_reg[VF_BIG] && !(flags_reg[VF_NEG] && (acc_reg != '0))
                    && (acc_reg >= lo_limit) && (acc_reg <= hi_limit);
        res_eol   = '{hit: 1'b0, command: CMD_QUERY, rate: '0};
        if (question_reg)
        begin
            res_eol.hit = 1'b1;
        end
        else if (live && cand_f[CAND_RATE])
        begin
            if (rate_ok_f)
            begin
                res_eol.hit     = 1'b1;
                res_eol.command = CMD_RATE;
                res_eol.rate    = acc_reg;
            end
        end
        else if (live && has_value)
        begin
            res_eol.hit     = 1'b1;
            res_eol.command = (on_pos_reg == 2'd2) ? CMD_PUMP_ON : CMD_PUMP_OFF;
        end
    end

    // next parse state
    always_comb
    begin
        logic is_eol, do_key, do_resolve, do_val, clear_all;
        is_eol        = (byte_in == CH_CR) || (byte_in == CH_LF);
        do_key        = 1'b0;
        do_resolve    = 1'b0;
        do_val        = 1'b0;
        clear_all     = 1'b0;
        count_next    = count_reg;
        phase_next    = phase_reg;
        key_pos_next  = key_pos_reg;
        cand_next     = cand_reg;
        on_pos_next   = on_pos_reg;
        acc_next      = acc_reg;
        flags_next    = flags_reg;
        question_next = question_reg;
        ended_next    = ended_reg;
        res           = '{hit: 1'b0, command: CMD_QUERY, rate: '0};

        if (step)
        begin
            if (is_eol)
            begin
                res       = res_eol;
                clear_all = 1'b1;
            end
            else
            begin
                if (byte_in == CH_NUL)
                begin
                    ended_next = 1'b1;
                end
                else if (!ended_reg)
                begin
                    if (byte_in == CH_QM)
                        question_next = 1'b1;
                    case (phase_reg)
                        PH_BEFORE_KEY:
                        begin
                            if (byte_in != CH_EQ)
                            begin
                                phase_next = PH_IN_KEY;
                                do_key     = 1'b1;
                            end
                        end
                        PH_IN_KEY:
                        begin
                            if (byte_in == CH_EQ)
                                do_resolve = 1'b1;
                            else
                                do_key = 1'b1;
                        end
                        PH_BEFORE_VAL:
                        begin
                            if (byte_in != CH_EQ)
                            begin
                                phase_next = PH_IN_VAL;
                                do_val     = 1'b1;
                            end
                        end
                        PH_IN_VAL:
                        begin
                            if (byte_in == CH_EQ)
                                phase_next = PH_VAL_DONE;
                            else
                                do_val = 1'b1;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                    if (do_key)
                    begin
                        key_pos_next = key_pos_k;
                        cand_next    = cand_k;
                    end
                    if (do_resolve)
                    begin
                        cand_next  = cand_res;
                        phase_next = (cand_res != 2'b00) ? PH_BEFORE_VAL : PH_IGNORE;
                    end
                    if (do_val)
                    begin
                        on_pos_next = on_pos_v;
                        acc_next    = acc_v;
                        flags_next  = flags_v;
                    end
                end
                // long line restarts parsing
                if (count_reg == CNT_LAST)
                    clear_all = 1'b1;
                else
                    count_next = count_reg + 1'b1;
            end

            if (clear_all)
            begin
                count_next    = '0;
                phase_next    = PH_BEFORE_KEY;
                key_pos_next  = '0;
                cand_next     = 2'b11;
                on_pos_next   = '0;
                acc_next      = '0;
                flags_next    = '0;
                question_next = 1'b0;
                ended_next    = 1'b0;
            end
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            phase_reg    <= PH_BEFORE_KEY;
            key_pos_reg  <= '0;
            cand_reg     <= 2'b11;
            on_pos_reg   <= '0;
            acc_reg      <= '0;
            flags_reg    <= '0;
            question_reg <= 1'b0;
            ended_reg    <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            phase_reg    <= phase_next;
            key_pos_reg  <= key_pos_next;
            cand_reg     <= cand_next;
            on_pos_reg   <= on_pos_next;
            acc_reg      <= acc_next;
            flags_reg    <= flags_next;
            question_reg <= question_next;
            ended_reg    <= ended_next;
        end
    end

endmodule

/* hdl/serial_line_command_parser.sv */
// Serial line command parser: takes one received byte per word on the rx channel and gives a
// command word on the res channel at a CR or LF that ends a recognised line (flow query for a
// line holding '?', set rate for FLOWRATE=<n> within the low and high rate limits, pump on or
// off for FLOWSTATE=<token>). Each byte goes from an input register through the parse logic into
// the result register, so a byte is taken every cycle and a result is offered once the parse
// logic has taken the CR or LF; the only stall is a result waiting in the output register.
// Lines of LINE_LIMIT bytes without an end of line are dropped and parsing restarts.
module serial_line_command_parser #(
    parameter int LINE_LIMIT = slcp_pkg::LINE_LIMIT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rx_valid,
    output logic                        rx_ready,
    input  logic [7:0]                  rx_byte,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic [1:0]                  command,
    output logic [slcp_pkg::RATE_W-1:0] rate_value,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [slcp_pkg::RATE_W-1:0] cfg_data
);
    import slcp_pkg::*;
    `include "serial_line_command_parser_defines.svh"

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    cmd_t              out_cmd_reg;
    logic [RATE_W-1:0] out_rate_reg;
    logic [RATE_W-1:0] lo_limit_reg;
    logic [RATE_W-1:0] hi_limit_reg;
    logic              advance;
    res_t              res;

    // a byte moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || res_ready);
    assign rx_ready = !in_valid_reg || advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_limit_reg <= RATE_MIN_RST;
            hi_limit_reg <= RATE_MAX_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RATE_MIN: lo_limit_reg <= cfg_data;
                CFG_RATE_MAX: hi_limit_reg <= cfg_data;
                default:      lo_limit_reg <= lo_limit_reg;
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx_valid && rx_ready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
            in_byte_reg <= rx_byte;
    end

    // parse logic
    slcp_core #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .byte_in  (in_byte_reg),
        .lo_limit (lo_limit_reg),
        .hi_limit (hi_limit_reg),
        .res      (res)
    );

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && res.hit)
            out_valid_reg <= 1'b1;
        else if (res_ready)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance && res.hit)
        begin
            out_cmd_reg  <= res.command;
            out_rate_reg <= res.rate;
        end
    end

    assign res_valid  = out_valid_reg;
    assign command    = out_cmd_reg;
    assign rate_value = out_rate_reg;

    // checks
    `SLCP_ASSERT_NOW(a_rate_only_for_set, clk, rst_n,
        res_valid && (command != CMD_RATE), rate_value == '0, "rate on a non-rate command")
    `SLCP_ASSERT_NOW(a_stall_only_when_full, clk, rst_n,
        !rx_ready, res_valid && !res_ready, "input stalled without a waiting result")
    `SLCP_ASSERT_NEXT(a_result_kept, clk, rst_n,
        res_valid && !res_ready, res_valid && $stable(rate_value), "waiting result lost")

endmodule
